// ===== sv/swal_pkg.sv =====
// ----------------------------------------------------------------------------
// swal_pkg
// Shared types and constants of the sensor window alarm log.
// ----------------------------------------------------------------------------
`default_nettype none

package swal_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CHECK = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	// input beat, first field in the highest bits
	typedef struct packed {
		logic [7:0]         max_entries;
		logic [31:0]        timestamp;
		logic signed [31:0] sample;
		logic signed [31:0] high_limit;
		logic signed [31:0] low_limit;
		logic [7:0]         sensor_num;
	} in_data_t;

	// output beat, padded to whole bytes
	typedef struct packed {
		logic [5:0]         pad;
		logic signed [31:0] entry_limit;
		logic signed [31:0] entry_value;
		logic [7:0]         entry_sensor;
		logic [31:0]        entry_time;
		logic               breach;
		logic               status;
	} out_data_t;

	typedef struct packed {
		logic signed [31:0] high_limit;
		logic signed [31:0] low_limit;
	} window_t;

	typedef struct packed {
		logic signed [31:0] limit;
		logic signed [31:0] value;
		logic [7:0]         sensor;
		logic [31:0]        time_stamp;
	} log_entry_t;

	localparam int IN_TDATA_W  = $bits(in_data_t);
	localparam int OUT_TDATA_W = $bits(out_data_t);
	localparam int WIN_W       = $bits(window_t);
	localparam int LOG_W       = $bits(log_entry_t);

endpackage

`default_nettype wire

// ===== sv/sensor_window_alarm_log_core.sv =====
// ----------------------------------------------------------------------------
// sensor_window_alarm_log_core
// Per-sensor alarm windows and a circular breach log with replay.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                  tuser        tlast
// s_axis   in   sensor_num, low, high, sample, time,   op           -
//               max_entries
// m_axis   out  status, breach, time, sensor, value,   entry_valid  last result
//               limit
//
// Set, check and an empty read go through accept, then table lookup and
// update from the registered window RAM read. A read of n entries streams
// them from the log RAM's read port, one entry a cycle while the output is not stalled.
// Reset clears the armed flags, log write slot and entry count and handshake state at once.
// A stalled output holds the sequencer in place; no new beat is taken until
// the last result of the current one has entered the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_window_alarm_log_core #(
	parameter int SENSOR_COUNT = 16,
	parameter int LOG_DEPTH    = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// sensor_num, low_limit, high_limit, sample, timestamp, max_entries
	input  wire logic [swal_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// op
	input  wire logic [1:0]                          s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// status, breach, entry_time, entry_sensor, entry_value, entry_limit, pad
	output logic      [swal_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// entry_valid
	output logic                                     m_axis_tuser,
	output logic                                     m_axis_tlast
);

	localparam int SID_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int LW    = $clog2(LOG_DEPTH);
	localparam int CW    = $clog2(LOG_DEPTH + 1);
	localparam logic [7:0] SC8 = 8'(SENSOR_COUNT);
	localparam logic [LW-1:0] LAST_SLOT = LW'(LOG_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(LOG_DEPTH);

	swal_pkg::in_data_t  in_d;
	swal_pkg::state_t    state_q, state_d;

	swal_pkg::op_t       op_q;
	logic [7:0]          id_q;
	logic [SID_W-1:0]    idx_q;
	logic                id_ok_q;
	logic signed [31:0]  low_q, high_q, sample_q;
	logic [31:0]         time_q;
	logic [7:0]          maxn_q;

	logic [SENSOR_COUNT-1:0] armed_q;
	logic [LW-1:0]       wslot_q;
	logic [CW-1:0]       held_q;
	logic [LW-1:0]       rptr_q;
	logic [swal_pkg::RCNT_W-1:0] rem_q;

	logic                ovalid_q, ouser_q, olast_q;
	swal_pkg::out_data_t odata_q;

	logic                accept, free;
	logic [7:0]          id_m1;
	logic                win_re;
	swal_pkg::window_t   win_rdata;
	swal_pkg::log_entry_t log_rdata, log_wdata;
	logic                win_we, log_we, log_re, arm;
	logic [LW-1:0]       log_raddr;
	logic                push, push_user, push_last;
	swal_pkg::out_data_t push_data;
	logic                rd_load, rd_adv;
	logic [7:0]          held8, n1;
	logic [swal_pkg::RCNT_W-1:0] n;
	logic [CW-1:0]       ws_ext, start_c;
	logic [LW-1:0]       start;
	logic [LW-1:0]       start_nxt, rptr_nxt, wslot_nxt;

	assign in_d   = swal_pkg::in_data_t'(s_axis_tdata);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign free   = !ovalid_q || m_axis_tready;
	assign id_m1  = in_d.sensor_num - 8'd1;

	assign s_axis_tready = (state_q == swal_pkg::ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ouser_q;
	assign m_axis_tlast  = olast_q;

	// read count and oldest slot
	assign held8   = 8'(held_q);
	assign n1      = (maxn_q < held8) ? maxn_q : held8;
	assign n       = (n1 > 8'(swal_pkg::MAX_RESULTS)) ?
	                 swal_pkg::RCNT_W'(swal_pkg::MAX_RESULTS) : swal_pkg::RCNT_W'(n1);
	assign ws_ext  = CW'(wslot_q);
	assign start_c = (ws_ext >= held_q) ? (ws_ext - held_q) : (ws_ext + DEPTH_C - held_q);
	assign start   = start_c[LW-1:0];
	assign start_nxt = (start == LAST_SLOT) ? '0 : start + 1'b1;
	assign rptr_nxt  = (rptr_q == LAST_SLOT) ? '0 : rptr_q + 1'b1;
	assign wslot_nxt = (wslot_q == LAST_SLOT) ? '0 : wslot_q + 1'b1;

	assign win_re = accept;

	swal_ram #(
		.WIDTH(swal_pkg::WIN_W),
		.DEPTH(SENSOR_COUNT)
	) u_win_ram (
		.clk  (clk),
		.we   (win_we),
		.waddr(idx_q),
		.wdata(swal_pkg::window_t'({high_q, low_q})),
		.re   (win_re),
		.raddr(id_m1[SID_W-1:0]),
		.rdata(win_rdata)
	);

	swal_ram #(
		.WIDTH(swal_pkg::LOG_W),
		.DEPTH(LOG_DEPTH)
	) u_log_ram (
		.clk  (clk),
		.we   (log_we),
		.waddr(wslot_q),
		.wdata(log_wdata),
		.re   (log_re),
		.raddr(log_raddr),
		.rdata(log_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swal_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = swal_pkg::ST_EXEC;
				end
			end
			swal_pkg::ST_EXEC: begin
				if (op_q == swal_pkg::OP_READ && n != '0) begin
					state_d = swal_pkg::ST_READ;
				end else if (free) begin
					state_d = swal_pkg::ST_IDLE;
				end
			end
			swal_pkg::ST_READ: begin
				if (free && rem_q == swal_pkg::RCNT_W'(1)) begin
					state_d = swal_pkg::ST_IDLE;
				end
			end
			default: state_d = swal_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		push      = 1'b0;
		push_user = 1'b0;
		push_last = 1'b1;
		push_data = '0;
		win_we    = 1'b0;
		arm       = 1'b0;
		log_we    = 1'b0;
		log_re    = 1'b0;
		log_raddr = start;
		rd_load   = 1'b0;
		rd_adv    = 1'b0;
		log_wdata = swal_pkg::log_entry_t'({win_rdata.high_limit, sample_q, id_q, time_q});
		unique case (state_q)
			swal_pkg::ST_EXEC: begin
				case (op_q)
					swal_pkg::OP_SET: begin
						push = 1'b1;
						push_data.status = !id_ok_q || (low_q > high_q);
						win_we = free && !push_data.status;
						arm    = win_we;
					end
					swal_pkg::OP_CHECK: begin
						push = 1'b1;
						push_data.status = !id_ok_q;
						if (id_ok_q && armed_q[idx_q]) begin
							if (sample_q > win_rdata.high_limit) begin
								push_data.breach = 1'b1;
								log_wdata.limit  = win_rdata.high_limit;
							end else if (sample_q < win_rdata.low_limit) begin
								push_data.breach = 1'b1;
								log_wdata.limit  = win_rdata.low_limit;
							end
						end
						if (push_data.breach) begin
							push_user              = 1'b1;
							push_data.entry_time   = time_q;
							push_data.entry_sensor = id_q;
							push_data.entry_value  = sample_q;
							push_data.entry_limit  = log_wdata.limit;
						end
						log_we = free && push_data.breach;
					end
					swal_pkg::OP_READ: begin
						if (n == '0) begin
							push = 1'b1;
						end else begin
							log_re  = 1'b1;
							rd_load = 1'b1;
						end
					end
					default: begin
						push = 1'b1;
						push_data.status = 1'b1;
					end
				endcase
			end
			swal_pkg::ST_READ: begin
				push      = 1'b1;
				push_user = 1'b1;
				push_last = (rem_q == swal_pkg::RCNT_W'(1));
				push_data.entry_time   = log_rdata.time_stamp;
				push_data.entry_sensor = log_rdata.sensor;
				push_data.entry_value  = log_rdata.value;
				push_data.entry_limit  = log_rdata.limit;
				log_raddr = rptr_q;
				rd_adv    = free;
				log_re    = free && !push_last;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= swal_pkg::ST_IDLE;
			armed_q  <= '0;
			wslot_q  <= '0;
			held_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (arm) begin
				armed_q[idx_q] <= 1'b1;
			end
			if (log_we) begin
				wslot_q <= wslot_nxt;
				if (held_q != DEPTH_C) begin
					held_q <= held_q + 1'b1;
				end
			end
			if (push && free) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload and item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= swal_pkg::op_t'(s_axis_tuser);
			id_q     <= in_d.sensor_num;
			idx_q    <= id_m1[SID_W-1:0];
			id_ok_q  <= (in_d.sensor_num != 8'd0) && (in_d.sensor_num <= SC8);
			low_q    <= in_d.low_limit;
			high_q   <= in_d.high_limit;
			sample_q <= in_d.sample;
			time_q   <= in_d.timestamp;
			maxn_q   <= in_d.max_entries;
		end
		if (rd_load) begin
			rptr_q <= start_nxt;
			rem_q  <= n;
		end else if (rd_adv) begin
			if (log_re) begin
				rptr_q <= rptr_nxt;
			end
			rem_q <= rem_q - 1'b1;
		end
		if (push && free) begin
			odata_q <= push_data;
			ouser_q <= push_user;
			olast_q <= push_last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/swal_ram.sv =====
// ----------------------------------------------------------------------------
// swal_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/swal_checker.sv =====
// ----------------------------------------------------------------------------
// swal_checker
// Port-level checks on the sensor window alarm log core.
// ----------------------------------------------------------------------------
`default_nettype none

module swal_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic [swal_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input wire logic [1:0]                        s_axis_tuser,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [swal_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input wire logic                              m_axis_tuser,
	input wire logic                              m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed under stall");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second beat taken while an item is in work");

	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && !m_axis_tdata[1])
		else $error("result without entry must be single and without breach");

	a_breach_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tuser && !m_axis_tdata[0])
		else $error("breach result must carry an accepted entry");

endmodule

bind sensor_window_alarm_log_core swal_checker u_swal_checker (.*);

`default_nettype wire
